[sv/kfls_pkg.sv]
// ----------------------------------------------------------------------------
// kfls_pkg
// Shared types and constants for the keyframe linear sampler: field widths,
// stream word layout, operation and register codes, controller states and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package kfls_pkg;

    localparam int DEF_MAX_KEYFRAMES = 64;

    localparam int COUNT_W = 7;
    localparam int TIME_W  = 32;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 6;
    localparam int FRAC_W  = 16;
    localparam int STEP_W  = 4;

    // one table entry: time, then x, y, z, w
    localparam int ENTRY_W = TIME_W + 4 * VALUE_W;

    // input word layout
    localparam int S_INDEX_LSB = 0;
    localparam int S_ENTRY_LSB = S_INDEX_LSB + INDEX_W;
    localparam int S_QUERY_LSB = S_ENTRY_LSB + ENTRY_W;
    localparam int S_TDATA_W   = 200;
    localparam int M_TDATA_W   = 4 * VALUE_W;

    localparam int CFG_DATA_W = 32;

    // 1.0 in q16.16, one bit wider than a time
    localparam logic [TIME_W:0] ONE_Q16 = 33'h1_0000;

    localparam logic [COUNT_W-1:0] COUNT_RESET    = 7'd1;
    localparam logic [TIME_W-1:0]  MAX_TIME_RESET = 32'd0;

    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(FRAC_W - 1);
    localparam logic [STEP_W-1:0] MIX_LAST = STEP_W'(3);

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic {
        REG_KEYFRAME_COUNT = 1'b0,
        REG_MAX_TIME       = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RD_LO,
        ST_RD_HI,
        ST_LATCH_HI,
        ST_CHECK,
        ST_DIV,
        ST_MIX,
        ST_MIX_END,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_LO,
        RD_HI
    } rd_sel_t;

    typedef struct packed {
        logic       load;
        logic       start;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       latch_lo;
        logic       latch_hi;
        logic       check;
        logic       div_step;
        logic       mix_mul;
        logic [1:0] mix_sel;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic scan_none;
        logic exact;
        logic saturate;
        logic out_free;
    } sts_t;

endpackage

[sv/kfls_ctrl.sv]
// ----------------------------------------------------------------------------
// kfls_ctrl
// Sequencer for the sampler: takes input words, walks a query through the
// table scan, bound reads, divide and per-component mix, and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module kfls_ctrl #(
    parameter int MAX_KEYFRAMES = kfls_pkg::DEF_MAX_KEYFRAMES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  kfls_pkg::op_t                  s_op,
    output kfls_pkg::cmd_t                 cmd,
    input  kfls_pkg::sts_t                 sts,
    output logic [$clog2(MAX_KEYFRAMES)-1:0] scan_addr
);

    localparam int AW = $clog2(MAX_KEYFRAMES);

    kfls_pkg::state_t               state_reg, state_next;
    logic [AW-1:0]                  scan_cnt_reg, scan_cnt_next;
    logic [kfls_pkg::STEP_W-1:0]    step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= kfls_pkg::ST_IDLE;
            scan_cnt_reg <= '0;
            step_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            step_reg     <= step_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            kfls_pkg::ST_IDLE: begin
                if (s_tvalid && s_op == kfls_pkg::OP_QUERY) begin
                    state_next = sts.scan_none ? kfls_pkg::ST_RD_LO : kfls_pkg::ST_SCAN;
                end
            end
            kfls_pkg::ST_SCAN: begin
                if (sts.scan_last) begin
                    state_next = kfls_pkg::ST_DRAIN;
                end
            end
            kfls_pkg::ST_DRAIN:    state_next = kfls_pkg::ST_RD_LO;
            kfls_pkg::ST_RD_LO:    state_next = kfls_pkg::ST_RD_HI;
            kfls_pkg::ST_RD_HI:    state_next = kfls_pkg::ST_LATCH_HI;
            kfls_pkg::ST_LATCH_HI: state_next = kfls_pkg::ST_CHECK;
            kfls_pkg::ST_CHECK: begin
                if (sts.exact) begin
                    state_next = kfls_pkg::ST_DONE;
                end else if (sts.saturate) begin
                    state_next = kfls_pkg::ST_MIX;
                end else begin
                    state_next = kfls_pkg::ST_DIV;
                end
            end
            kfls_pkg::ST_DIV: begin
                if (step_reg == kfls_pkg::DIV_LAST) begin
                    state_next = kfls_pkg::ST_MIX;
                end
            end
            kfls_pkg::ST_MIX: begin
                if (step_reg == kfls_pkg::MIX_LAST) begin
                    state_next = kfls_pkg::ST_MIX_END;
                end
            end
            kfls_pkg::ST_MIX_END:  state_next = kfls_pkg::ST_DONE;
            kfls_pkg::ST_DONE: begin
                if (sts.out_free) begin
                    state_next = kfls_pkg::ST_IDLE;
                end
            end
            default:               state_next = kfls_pkg::ST_IDLE;
        endcase
    end

    // counters
    always_comb begin
        scan_cnt_next = scan_cnt_reg;
        step_next     = step_reg;
        case (state_reg)
            kfls_pkg::ST_IDLE:  scan_cnt_next = '0;
            kfls_pkg::ST_SCAN:  scan_cnt_next = scan_cnt_reg + AW'(1);
            kfls_pkg::ST_CHECK: step_next = '0;
            kfls_pkg::ST_DIV: begin
                step_next = (step_reg == kfls_pkg::DIV_LAST) ? '0
                                                             : step_reg + kfls_pkg::STEP_W'(1);
            end
            kfls_pkg::ST_MIX:   step_next = step_reg + kfls_pkg::STEP_W'(1);
            default: begin
                scan_cnt_next = scan_cnt_reg;
                step_next     = step_reg;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd       = '0;
        cmd.rd_sel = kfls_pkg::RD_SCAN;
        s_tready  = 1'b0;
        scan_addr = scan_cnt_reg;
        case (state_reg)
            kfls_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.load  = s_tvalid && s_op == kfls_pkg::OP_LOAD;
                cmd.start = s_tvalid && s_op == kfls_pkg::OP_QUERY;
            end
            kfls_pkg::ST_SCAN: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = kfls_pkg::RD_SCAN;
            end
            kfls_pkg::ST_RD_LO: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = kfls_pkg::RD_LO;
            end
            kfls_pkg::ST_RD_HI: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = kfls_pkg::RD_HI;
                cmd.latch_lo = 1'b1;
            end
            kfls_pkg::ST_LATCH_HI: cmd.latch_hi = 1'b1;
            kfls_pkg::ST_CHECK:    cmd.check    = 1'b1;
            kfls_pkg::ST_DIV:      cmd.div_step = 1'b1;
            kfls_pkg::ST_MIX: begin
                cmd.mix_mul = 1'b1;
                cmd.mix_sel = step_reg[1:0];
            end
            kfls_pkg::ST_DONE:     cmd.out_load = sts.out_free;
            default:               cmd = '0;
        endcase
    end

`ifndef ASSERT_OFF
    ap_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded while output word still held");

    ap_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == kfls_pkg::ST_DIV |=>
            (state_reg == kfls_pkg::ST_DIV || state_reg == kfls_pkg::ST_MIX))
        else $error("divide left to a wrong state");

    ap_scan_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kfls_pkg::ST_SCAN && sts.scan_last) |=> state_reg == kfls_pkg::ST_DRAIN)
        else $error("scan did not stop at the last keyframe");

    ap_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> (state_reg == kfls_pkg::ST_SCAN || state_reg == kfls_pkg::ST_RD_LO))
        else $error("query did not enter the scan");
`endif

endmodule

[sv/kfls_dpath.sv]
// ----------------------------------------------------------------------------
// kfls_dpath
// Keyframe table, configuration registers, bound search, bit-serial
// fraction divider, shared mix multiplier and the output word register.
// ----------------------------------------------------------------------------
module kfls_dpath #(
    parameter int MAX_KEYFRAMES = kfls_pkg::DEF_MAX_KEYFRAMES
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [kfls_pkg::S_TDATA_W-1:0]     s_tdata,
    input  kfls_pkg::cmd_t                     cmd,
    output kfls_pkg::sts_t                     sts,
    input  logic [$clog2(MAX_KEYFRAMES)-1:0]   scan_addr,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [kfls_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  kfls_pkg::cfg_reg_t                 cfg_index,
    input  logic [kfls_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW   = $clog2(MAX_KEYFRAMES);
    localparam int CW   = (AW + 1 > kfls_pkg::COUNT_W) ? AW + 1 : kfls_pkg::COUNT_W;
    localparam int TW   = kfls_pkg::TIME_W;
    localparam int VW   = kfls_pkg::VALUE_W;
    localparam int DW   = TW + 3;
    localparam int FW   = kfls_pkg::FRAC_W;
    localparam int PW   = (VW + 1) + (FW + 2);
    localparam logic signed [DW-1:0] LO_NONE = -$signed({2'b00, kfls_pkg::ONE_Q16});

    // keyframe table
    logic [kfls_pkg::ENTRY_W-1:0] mem [MAX_KEYFRAMES];
    logic [kfls_pkg::ENTRY_W-1:0] rd_data_reg;
    logic [AW-1:0]                rd_addr;
    logic [AW-1:0]                wr_addr;
    logic                         load_ok;

    // configuration
    logic [kfls_pkg::COUNT_W-1:0] count_reg;
    logic [TW-1:0]                max_time_reg;
    logic [CW-1:0]                count_ext;
    logic [CW-1:0]                n_sat;

    // bound search
    logic [TW-1:0]   q_reg;
    logic            lo_valid_reg;
    logic [TW-1:0]   lo_time_reg;
    logic [AW-1:0]   lo_idx_reg;
    logic [TW:0]     hi_time_reg;
    logic [AW-1:0]   hi_idx_reg;
    logic            cmp_en_reg;
    logic [AW-1:0]   cmp_idx_reg;
    logic [TW-1:0]   t_rd;
    logic            take_lo;
    logic            take_hi;

    // bounds and fraction
    logic [TW-1:0]          a_time_reg;
    logic [VW-1:0]          a_val_reg [4];
    logic signed [VW:0]     diff_reg [4];
    logic signed [DW-1:0]   lo_ext;
    logic signed [DW-1:0]   num_reg;
    logic signed [DW-1:0]   den_reg;
    logic                   sat_reg;
    logic                   hit_reg;
    logic [DW-1:0]          rem_reg;
    logic [FW-1:0]          quot_reg;
    logic [DW-1:0]          rem_sh;
    logic [FW:0]            frac;
    logic signed [FW+1:0]   frac_s;

    // mix
    logic signed [PW-1:0]   prod_reg;
    logic                   acc_en_reg;
    logic [1:0]             acc_sel_reg;
    logic [VW-1:0]          res_reg [4];

    // output word
    logic                         m_tvalid_reg;
    logic [kfls_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                         m_tuser_reg;

    assign cfg_ready = 1'b1;

    assign load_ok = 32'(s_tdata[kfls_pkg::S_INDEX_LSB +: kfls_pkg::INDEX_W])
                     < 32'(MAX_KEYFRAMES);
    assign wr_addr = AW'(s_tdata[kfls_pkg::S_INDEX_LSB +: kfls_pkg::INDEX_W]);

    always_comb begin
        case (cmd.rd_sel)
            kfls_pkg::RD_SCAN: rd_addr = scan_addr;
            kfls_pkg::RD_LO:   rd_addr = lo_idx_reg;
            kfls_pkg::RD_HI:   rd_addr = hi_idx_reg;
            default:           rd_addr = scan_addr;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && load_ok) begin
            mem[wr_addr] <= s_tdata[kfls_pkg::S_ENTRY_LSB +: kfls_pkg::ENTRY_W];
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= kfls_pkg::COUNT_RESET;
            max_time_reg <= kfls_pkg::MAX_TIME_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                kfls_pkg::REG_KEYFRAME_COUNT: count_reg <= cfg_data[kfls_pkg::COUNT_W-1:0];
                kfls_pkg::REG_MAX_TIME:       max_time_reg <= cfg_data[TW-1:0];
                default:                      count_reg <= count_reg;
            endcase
        end
    end

    assign count_ext = CW'(count_reg);
    assign n_sat     = (count_ext > CW'(MAX_KEYFRAMES)) ? CW'(MAX_KEYFRAMES) : count_ext;

    assign t_rd    = rd_data_reg[TW-1:0];
    assign take_lo = cmp_en_reg && (t_rd <= q_reg)
                     && (!lo_valid_reg || t_rd > lo_time_reg);
    assign take_hi = cmp_en_reg && (t_rd >= q_reg) && ({1'b0, t_rd} < hi_time_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_en_reg   <= 1'b0;
            lo_valid_reg <= 1'b0;
        end else begin
            cmp_en_reg <= cmd.rd_en && cmd.rd_sel == kfls_pkg::RD_SCAN;
            if (cmd.start) begin
                lo_valid_reg <= 1'b0;
            end else if (take_lo) begin
                lo_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= scan_addr;
        if (cmd.start) begin
            q_reg       <= s_tdata[kfls_pkg::S_QUERY_LSB +: TW];
            lo_idx_reg  <= '0;
            hi_time_reg <= {1'b0, max_time_reg} + kfls_pkg::ONE_Q16;
            hi_idx_reg  <= '0;
        end else begin
            if (take_lo) begin
                lo_time_reg <= t_rd;
                lo_idx_reg  <= cmp_idx_reg;
            end
            if (take_hi) begin
                hi_time_reg <= {1'b0, t_rd};
                hi_idx_reg  <= cmp_idx_reg;
            end
        end
    end

    assign lo_ext = lo_valid_reg ? $signed({3'b000, lo_time_reg}) : LO_NONE;
    assign rem_sh = {rem_reg[DW-2:0], 1'b0};
    assign frac   = sat_reg ? kfls_pkg::ONE_Q16[FW:0] : {1'b0, quot_reg};
    assign frac_s = $signed({1'b0, frac});

    always_ff @(posedge aclk) begin
        if (cmd.latch_lo) begin
            a_time_reg <= t_rd;
            for (int k = 0; k < 4; k++) begin
                a_val_reg[k] <= rd_data_reg[TW + k * VW +: VW];
            end
            num_reg <= $signed({3'b000, q_reg}) - lo_ext;
            den_reg <= $signed({2'b00, hi_time_reg}) - lo_ext;
        end
        if (cmd.latch_hi) begin
            for (int k = 0; k < 4; k++) begin
                diff_reg[k] <= $signed({rd_data_reg[TW + k * VW + VW - 1],
                                        rd_data_reg[TW + k * VW +: VW]})
                             - $signed({a_val_reg[k][VW-1], a_val_reg[k]});
            end
        end
        if (cmd.check) begin
            hit_reg  <= sts.exact;
            sat_reg  <= sts.saturate;
            rem_reg  <= num_reg;
            quot_reg <= '0;
        end
        if (cmd.div_step) begin
            if (rem_sh >= $unsigned(den_reg)) begin
                rem_reg  <= rem_sh - $unsigned(den_reg);
                quot_reg <= {quot_reg[FW-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                quot_reg <= {quot_reg[FW-2:0], 1'b0};
            end
        end
        if (cmd.mix_mul) begin
            prod_reg <= diff_reg[cmd.mix_sel] * frac_s;
        end
        acc_sel_reg <= cmd.mix_sel;
        if (cmd.check && sts.exact) begin
            for (int k = 0; k < 4; k++) begin
                res_reg[k] <= a_val_reg[k];
            end
        end else if (acc_en_reg) begin
            res_reg[acc_sel_reg] <= a_val_reg[acc_sel_reg] + prod_reg[FW +: VW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_en_reg <= 1'b0;
        end else begin
            acc_en_reg <= cmd.mix_mul;
        end
    end

    assign sts.scan_last = (CW'(scan_addr) + CW'(1)) == n_sat;
    assign sts.scan_none = (count_reg == '0);
    assign sts.exact     = (a_time_reg == q_reg);
    assign sts.saturate  = den_reg[DW-1] || (den_reg == '0) || num_reg[DW-1]
                           || (num_reg == '0) || (num_reg >= den_reg);
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
            m_tuser_reg <= hit_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    ap_lo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        lo_valid_reg |-> lo_time_reg <= q_reg)
        else $error("lower key lies after the query time");
`endif

endmodule

[sv/keyframe_linear_sampler_top.sv]
// ----------------------------------------------------------------------------
// keyframe_linear_sampler_top
// Keyframe table with linear sampling of a four-component q16.16 value.
// ----------------------------------------------------------------------------
// A load word writes one table slot in its accept cycle and gives no result.
// A query scans slots 0 to n-1 (n = keyframe_count, capped at MAX_KEYFRAMES),
// one slot per cycle through the single read port of the table, finds the
// lower and upper keys, then forms the q0.16 fraction in a one-bit-per-cycle
// divider and mixes the four components through one shared multiplier.
// An interpolated query goes through the scan, the bound reads, the check,
// the divide and the mix before its result word can be taken; an exact hit
// skips divide and mix, and a query that saturates the fraction skips the
// divide. With a keyframe count of zero the scan is skipped. Input words
// are taken only while no query is in flight; a finished result waits in
// the output register without blocking the next input word.
// ----------------------------------------------------------------------------
module keyframe_linear_sampler_top #(
    parameter int MAX_KEYFRAMES = kfls_pkg::DEF_MAX_KEYFRAMES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // key_index, key_time, value_x, value_y, value_z, value_w, query_time
    input  logic [kfls_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // result_x, result_y, result_z, result_w
    output logic [kfls_pkg::M_TDATA_W-1:0]   m_tdata,
    // exact_hit
    output logic [0:0]                       m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [0:0]                       cfg_index,
    input  logic [kfls_pkg::CFG_DATA_W-1:0]  cfg_data
);

    kfls_pkg::cmd_t                     cmd;
    kfls_pkg::sts_t                     sts;
    logic [$clog2(MAX_KEYFRAMES)-1:0]   scan_addr;
    kfls_pkg::op_t                      s_op;
    kfls_pkg::cfg_reg_t                 cfg_reg;

    assign s_op    = kfls_pkg::op_t'(s_tuser[0]);
    assign cfg_reg = kfls_pkg::cfg_reg_t'(cfg_index[0]);

    kfls_ctrl #(
        .MAX_KEYFRAMES (MAX_KEYFRAMES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_op      (s_op),
        .cmd       (cmd),
        .sts       (sts),
        .scan_addr (scan_addr)
    );

    kfls_dpath #(
        .MAX_KEYFRAMES (MAX_KEYFRAMES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .scan_addr (scan_addr),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser[0]),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_reg),
        .cfg_data  (cfg_data)
    );

endmodule

[verif/keyframe_linear_sampler_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyframe_linear_sampler_top_test
// Self-checking bench for the keyframe linear sampler. Keyframe tables are
// loaded through the input stream and sampled by query words; a behavioral
// model of the lookup and q16.16 blend predicts each result word, which is
// compared field by field as it leaves the block under random idling and
// output backpressure.
// ----------------------------------------------------------------------------
module keyframe_linear_sampler_top_test;

    localparam int     NUM_SLOTS     = kfls_pkg::DEF_MAX_KEYFRAMES;
    localparam int     IDLE_LIMIT    = 4000;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     FINAL_CYCLES  = 100;
    localparam longint Q16_ONE       = 64'sd65536;

    typedef struct packed {
        logic [kfls_pkg::VALUE_W-1:0] x, y, z, w;
        logic                         hit;
    } sample_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [kfls_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic [0:0]                       s_tuser   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [kfls_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [0:0]                       m_tuser;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [0:0]                       cfg_index = '0;
    logic [kfls_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // model of the keyframe table and registers
    logic [kfls_pkg::TIME_W-1:0]  key_time_tab [NUM_SLOTS];
    logic [kfls_pkg::VALUE_W-1:0] key_val_tab  [NUM_SLOTS][4];
    bit                           slot_loaded  [NUM_SLOTS];
    logic [kfls_pkg::COUNT_W-1:0] cur_count    = kfls_pkg::COUNT_RESET;
    logic [kfls_pkg::TIME_W-1:0]  cur_max_time = kfls_pkg::MAX_TIME_RESET;
    sample_t                      pending_samples [$];

    int tx_idle_pct     = 0;
    int rx_stall_pct    = 0;
    int hold_req        = 0;
    int hold_seen       = 0;
    int hold_left       = 0;
    int idle_cycles     = 0;
    int mismatch_count  = 0;
    int items_sent      = 0;
    int loads_sent      = 0;
    int queries_sent    = 0;
    int samples_checked = 0;
    int cfg_writes      = 0;

    keyframe_linear_sampler_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic logic [kfls_pkg::VALUE_W-1:0] blend(
        logic [kfls_pkg::VALUE_W-1:0] a_bits, logic [kfls_pkg::VALUE_W-1:0] b_bits,
        longint frac);
        longint a, b, p;
        a = longint'(signed'(a_bits));
        b = longint'(signed'(b_bits));
        p = (b - a) * frac;
        return kfls_pkg::VALUE_W'(a + (p >>> kfls_pkg::FRAC_W));
    endfunction

    function automatic sample_t sample_at(logic [kfls_pkg::TIME_W-1:0] q_bits);
        int      n, i, lo_i, hi_i;
        bit      lo_found;
        longint  q, t, lo, hi, num, den, frac;
        sample_t s;
        n = (cur_count > NUM_SLOTS) ? NUM_SLOTS : int'(cur_count);
        q = longint'(q_bits);
        lo = -Q16_ONE;
        hi = longint'(cur_max_time) + Q16_ONE;
        lo_i = 0;
        hi_i = 0;
        lo_found = 1'b0;
        for (i = 0; i < n; i++) begin
            t = longint'(key_time_tab[i]);
            if (t <= q && (!lo_found || t > lo)) begin
                lo = t;
                lo_i = i;
                lo_found = 1'b1;
            end
            if (t >= q && t < hi) begin
                hi = t;
                hi_i = i;
            end
        end
        if (q_bits == key_time_tab[lo_i]) begin
            s.x = key_val_tab[lo_i][0];
            s.y = key_val_tab[lo_i][1];
            s.z = key_val_tab[lo_i][2];
            s.w = key_val_tab[lo_i][3];
            s.hit = 1'b1;
            return s;
        end
        den = hi - lo;
        num = q - lo;
        if (den <= 0 || num <= 0) begin
            frac = Q16_ONE;
        end else begin
            frac = (num * Q16_ONE) / den;
            if (frac > Q16_ONE) frac = Q16_ONE;
        end
        s.x = blend(key_val_tab[lo_i][0], key_val_tab[hi_i][0], frac);
        s.y = blend(key_val_tab[lo_i][1], key_val_tab[hi_i][1], frac);
        s.z = blend(key_val_tab[lo_i][2], key_val_tab[hi_i][2], frac);
        s.w = blend(key_val_tab[lo_i][3], key_val_tab[hi_i][3], frac);
        s.hit = 1'b0;
        return s;
    endfunction

    // true when every slot a query would read has been loaded
    function automatic bit scan_ready();
        int n, i;
        n = (cur_count == 0) ? 1 : ((cur_count > NUM_SLOTS) ? NUM_SLOTS : int'(cur_count));
        for (i = 0; i < n; i++)
            if (!slot_loaded[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [kfls_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    endtask

    task automatic send_word(kfls_pkg::op_t op, logic [kfls_pkg::INDEX_W-1:0] idx,
                             logic [kfls_pkg::TIME_W-1:0] t,
                             logic [kfls_pkg::VALUE_W-1:0] vx, vy, vz, vw,
                             logic [kfls_pkg::TIME_W-1:0] q);
        logic [kfls_pkg::S_TDATA_W-1:0] word;
        word = '0;
        word[kfls_pkg::S_INDEX_LSB +: kfls_pkg::INDEX_W] = idx;
        word[kfls_pkg::S_ENTRY_LSB +: kfls_pkg::ENTRY_W] = {vw, vz, vy, vx, t};
        word[kfls_pkg::S_QUERY_LSB +: kfls_pkg::TIME_W]  = q;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        if (op == kfls_pkg::OP_LOAD) begin
            key_time_tab[idx]   = t;
            key_val_tab[idx][0] = vx;
            key_val_tab[idx][1] = vy;
            key_val_tab[idx][2] = vz;
            key_val_tab[idx][3] = vw;
            slot_loaded[idx]    = 1'b1;
            loads_sent++;
        end else begin
            pending_samples.push_back(sample_at(q));
            queries_sent++;
        end
        items_sent++;
    endtask

    task automatic load_key(logic [kfls_pkg::INDEX_W-1:0] idx, logic [kfls_pkg::TIME_W-1:0] t,
                            logic [kfls_pkg::VALUE_W-1:0] vx, vy, vz, vw);
        send_word(kfls_pkg::OP_LOAD, idx, t, vx, vy, vz, vw, $urandom());
    endtask

    task automatic query_at(logic [kfls_pkg::TIME_W-1:0] q);
        send_word(kfls_pkg::OP_QUERY, kfls_pkg::INDEX_W'($urandom()), $urandom(), $urandom(),
                  $urandom(), $urandom(), $urandom(), q);
    endtask

    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(kfls_pkg::cfg_reg_t r, logic [kfls_pkg::CFG_DATA_W-1:0] d);
        settle_idle();
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (r == kfls_pkg::REG_KEYFRAME_COUNT) cur_count = d[kfls_pkg::COUNT_W-1:0];
        else cur_max_time = d;
        cfg_writes++;
    endtask

    task automatic send_noise();
        if ($urandom_range(1) == 0 || !scan_ready())
            load_key(kfls_pkg::INDEX_W'($urandom_range(NUM_SLOTS - 1)), $urandom(),
                     pick_value(), pick_value(), pick_value(), pick_value());
        else
            query_at($urandom());
    endtask

    // registers at their reset values: one key, upper bound at 1.0
    task automatic test_reset_values();
        load_key(kfls_pkg::INDEX_W'(0), 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000,
                 32'h1234_5678, 32'h8000_0000);
        query_at(32'h0002_0000);
        query_at(32'h0001_0000);
        query_at(32'h0003_0000);
    endtask

    // extreme times and values, tied key times, widest blend span
    task automatic test_extremes();
        write_reg(kfls_pkg::REG_KEYFRAME_COUNT, 4);
        write_reg(kfls_pkg::REG_MAX_TIME, 32'hFFFF_FFFF);
        load_key(kfls_pkg::INDEX_W'(0), 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h0000_0000, 32'hFFFF_FFFF);
        load_key(kfls_pkg::INDEX_W'(1), 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'hFFFF_FFFF, 32'h0000_0000);
        load_key(kfls_pkg::INDEX_W'(2), 32'h8000_0000, 32'h0000_0001, 32'h0000_0002,
                 32'h0000_0003, 32'h0000_0004);
        load_key(kfls_pkg::INDEX_W'(3), 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        load_key(kfls_pkg::INDEX_W'(63), 32'h0001_2345, 32'h1111_1111, 32'h2222_2222,
                 32'h3333_3333, 32'h4444_4444);
        query_at(32'h0000_0000);
        query_at(32'h0000_0001);
        query_at(32'h4000_0000);
        query_at(32'h8000_0000);
        query_at(32'hC000_0000);
        query_at(32'hFFFF_FFFE);
        query_at(32'hFFFF_FFFF);
    endtask

    // nothing scanned: slot 0 serves as both keys
    task automatic test_count_zero();
        write_reg(kfls_pkg::REG_KEYFRAME_COUNT, 0);
        query_at(32'h0000_0000);
        query_at(32'h0000_8000);
        query_at(32'hFFFF_FFFF);
    endtask

    // long receiver hold fills the output and stalls the input stream
    task automatic test_output_backpressure();
        int k;
        write_reg(kfls_pkg::REG_KEYFRAME_COUNT, 4);
        tx_idle_pct = 0;
        hold_req <= hold_req + 1;
        for (k = 0; k < 6; k++) query_at($urandom());
        settle_idle();
    endtask

    // ordered keyframe table with random content, then queries around its keys
    task automatic random_sequence();
        logic [kfls_pkg::TIME_W-1:0] times [NUM_SLOTS];
        logic [kfls_pkg::TIME_W-1:0] t, mt, step;
        int                          n, slots, nq, k, pick;
        pick = $urandom_range(99);
        if (pick < 5) n = 0;
        else if (pick < 70) n = $urandom_range(1, 12);
        else if (pick < 82) n = $urandom_range(13, 40);
        else if (pick < 92) n = NUM_SLOTS;
        else n = $urandom_range(NUM_SLOTS + 1, 127);
        slots = (n == 0) ? 1 : ((n > NUM_SLOTS) ? NUM_SLOTS : n);
        t = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 32'h0004_0000);
        for (k = 0; k < slots; k++) begin
            times[k] = t;
            step = ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(1, 32'h0003_0000);
            t = (t > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : t + step;
        end
        case ($urandom_range(3))
            0: mt = 32'd0;
            1: mt = 32'hFFFF_FFFF;
            2: mt = times[slots-1] + $urandom_range(0, 32'h0002_0000);
            default: mt = $urandom();
        endcase
        write_reg(kfls_pkg::REG_KEYFRAME_COUNT, n);
        write_reg(kfls_pkg::REG_MAX_TIME, mt);
        for (k = 0; k < slots; k++) begin
            if ($urandom_range(9) == 0) send_noise();
            load_key(kfls_pkg::INDEX_W'(k), times[k], pick_value(), pick_value(),
                     pick_value(), pick_value());
        end
        nq = $urandom_range(3, 10);
        repeat (nq) begin
            if ($urandom_range(9) == 0) send_noise();
            k = $urandom_range(slots - 1);
            case ($urandom_range(5))
                0: query_at(times[k]);
                1: query_at(times[k] + $urandom_range(1, 32'h0002_0000));
                2: query_at(times[0] - $urandom_range(1, 32'h0001_0000));
                3: query_at(mt + $urandom_range(0, 32'h0002_0000));
                4: query_at($urandom());
                default: query_at(times[slots-1] + $urandom_range(0, 32'h0000_4000));
            endcase
        end
    endtask

    task automatic run_random_phase(int target, int tx_pct, int rx_pct);
        int stop_at;
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
        stop_at = items_sent + target;
        while (items_sent < stop_at) random_sequence();
    endtask

    always @(posedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_samples.size() == 0) begin
                report_mismatch("unexpected result word", m_tdata[31:0], 32'd0);
            end else begin
                want = pending_samples.pop_front();
                samples_checked++;
                if (m_tdata[0*kfls_pkg::VALUE_W +: kfls_pkg::VALUE_W] !== want.x)
                    report_mismatch("result_x",
                                    m_tdata[0*kfls_pkg::VALUE_W +: kfls_pkg::VALUE_W], want.x);
                if (m_tdata[1*kfls_pkg::VALUE_W +: kfls_pkg::VALUE_W] !== want.y)
                    report_mismatch("result_y",
                                    m_tdata[1*kfls_pkg::VALUE_W +: kfls_pkg::VALUE_W], want.y);
                if (m_tdata[2*kfls_pkg::VALUE_W +: kfls_pkg::VALUE_W] !== want.z)
                    report_mismatch("result_z",
                                    m_tdata[2*kfls_pkg::VALUE_W +: kfls_pkg::VALUE_W], want.z);
                if (m_tdata[3*kfls_pkg::VALUE_W +: kfls_pkg::VALUE_W] !== want.w)
                    report_mismatch("result_w",
                                    m_tdata[3*kfls_pkg::VALUE_W +: kfls_pkg::VALUE_W], want.w);
                if (m_tuser[0] !== want.hit)
                    report_mismatch("exact_hit", {31'd0, m_tuser[0]}, {31'd0, want.hit});
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_extremes();
        test_count_zero();
        test_output_backpressure();
        run_random_phase(400, 6, 73);
        run_random_phase(400, 73, 6);
        run_random_phase(400, 0, 0);
        settle_idle();
        repeat (FINAL_CYCLES) @(posedge aclk);
        $display("covered %0d keyframe loads, %0d sample queries, %0d register writes",
                 loads_sent, queries_sent, cfg_writes);
        $display("%0d result words compared, %0d mismatches", samples_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
